// ===== sv/breqq_pkg.sv =====
// Package: shared types and codes of the block request elevator queue.
`timescale 1ns / 1ps
package breqq_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_SIZE_KB   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_ENABLE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_SKIPS_HEAD = 2'd2;

  typedef enum logic [3:0] {
    ST_BACK_MERGE  = 4'd0,
    ST_FRONT_MERGE = 4'd1,
    ST_QUEUED      = 4'd2,
    ST_AHEAD_DROP  = 4'd3,
    ST_PAST_END    = 4'd4,
    ST_SKIPPED     = 4'd5,
    ST_POOL_FULL   = 4'd6,
    ST_HEAD_TAKEN  = 4'd7,
    ST_EMPTY       = 4'd8
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE, FSM_CALC, FSM_CHECK, FSM_TAKE, FSM_MERGE, FSM_ALLOC,
    FSM_FIND, FSM_INS, FSM_WR_E, FSM_WR_T, FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [31:0] device_size_kb;
    logic        merge_enable;
    logic        merge_skips_head;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [5:0]  entry_index;
    logic        start_device;
    logic        head_is_write;
    logic [7:0]  head_unit;
    logic [31:0] head_sector;
    logic [7:0]  head_count;
  } res_t;

  typedef struct packed {
    logic        opcode;
    logic        is_write;
    logic        prefetch;
    logic [7:0]  unit;
    logic [28:0] block_number;
    logic [3:0]  sectors_per_block;
    logic        buffer_busy;
    logic        buffer_dirty;
    logic        buffer_valid;
  } req_t;

endpackage

// ===== sv/breqq_ram.sv =====
// Simple dual-port request pool memory (one write port, one read port) with registered read data.
`timescale 1ns / 1ps
module breqq_ram #(
  parameter int unsigned DW = 8,
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW = 2
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/breqq_ctrl.sv =====
// Sequencer: merge walk, free search, elevator insert and head take.
`timescale 1ns / 1ps
module breqq_ctrl #(
  parameter int unsigned POOL_DEPTH = 64,
  parameter int unsigned MERGE_LIMIT = 244
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  breqq_pkg::cfg_t     cfg_i,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  breqq_pkg::req_t     req_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output breqq_pkg::res_t     res_o
);
  import breqq_pkg::*;

  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned LW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned DW = 49 + LW;
  localparam int unsigned WR_LIMIT = (POOL_DEPTH * 2) / 3;
  localparam logic [LW-1:0] NONE = LW'(POOL_DEPTH);

  // record layout: {link, count, sector, unit, is_write}
  fsm_e state_q, state_d;
  req_t req_q, req_d;
  logic [31:0] sector_q, sector_d;
  logic [LW-1:0] head_q, head_d;
  logic [AW-1:0] sstart_q, sstart_d;
  logic [LW-1:0] slimit_q, slimit_d;
  logic [POOL_DEPTH-1:0] used_q, used_d;
  logic [AW-1:0] addr_q, addr_d, t_q, t_d, idx_q, idx_d, e_q, e_d;
  logic first_q, first_d;
  logic [LW-1:0] guard_q, guard_d, n_q, n_d;
  logic [DW-1:0] cur_q, cur_d;
  res_t res_q, res_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rd;

  breqq_ram #(.DW(DW), .DEPTH(POOL_DEPTH), .AW(AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rd)
  );

  logic        rd_wr, cur_wr;
  logic [7:0]  rd_unit, rd_cnt;
  logic [31:0] rd_sec;
  logic [LW-1:0] rd_link;
  logic [40:0] key_e, key_rd, key_cur;
  logic [32:0] end_sum;
  logic [8:0]  cnt_sum;
  logic [7:0]  cnt_sat;
  logic [LW-1:0] lim;
  logic [AW-1:0] nidx;
  logic [48:0] new_rec;
  logic        hd_ok, match_ok, back_hit, front_hit, brk;

  function automatic logic [5:0] idx6(input logic [AW-1:0] a);
    logic [AW+5:0] x;
    x = {6'd0, a};
    return x[5:0];
  endfunction

  always_comb begin
    rd_wr    = rd[0];
    rd_unit  = rd[8:1];
    rd_sec   = rd[40:9];
    rd_cnt   = rd[48:41];
    rd_link  = rd[49 +: LW];
    cur_wr   = cur_q[0];
    key_e    = {req_q.is_write, req_q.unit, sector_q};
    key_rd   = {rd_wr, rd_unit, rd_sec};
    key_cur  = {cur_wr, cur_q[8:1], cur_q[40:9]};
    end_sum  = {1'b0, sector_q} + {29'd0, req_q.sectors_per_block};
    cnt_sum  = {1'b0, rd_cnt} + {5'd0, req_q.sectors_per_block};
    cnt_sat  = cnt_sum[8] ? 8'hFF : cnt_sum[7:0];
    lim      = req_q.is_write ? LW'(WR_LIMIT) : LW'(POOL_DEPTH);
    nidx     = (idx_q != '0) ? idx_q - AW'(1) : AW'(lim - LW'(1));
    new_rec  = {4'd0, req_q.sectors_per_block, sector_q, req_q.unit, req_q.is_write};
    hd_ok    = head_q < NONE;
    match_ok = rd_unit == req_q.unit && rd_wr == req_q.is_write &&
               rd_cnt < 8'(MERGE_LIMIT);
    back_hit  = rd_sec + {24'd0, rd_cnt} == sector_q;
    front_hit = rd_sec - {28'd0, req_q.sectors_per_block} == sector_q;
    // elevator order: break where the new entry fits between t and n
    brk = ((key_cur < key_e) || !(key_cur < key_rd)) && (key_e < key_rd);
  end

  always_comb begin
    state_d = state_q; req_d = req_q; sector_d = sector_q; head_d = head_q;
    sstart_d = sstart_q; slimit_d = slimit_q; used_d = used_q;
    addr_d = addr_q; t_d = t_q; idx_d = idx_q; e_d = e_q; first_d = first_q;
    guard_d = guard_q; n_d = n_q; cur_d = cur_q; res_d = res_q;
    we = 1'b0; waddr = addr_q; wdata = rd; raddr = addr_q;
    req_ready_o = 1'b0; res_valid_o = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d = req_i;
          state_d = FSM_CALC;
        end
      end
      FSM_CALC: begin
        sector_d = {3'd0, req_q.block_number} * {28'd0, req_q.sectors_per_block};
        res_d = '0;
        state_d = FSM_CHECK;
      end
      FSM_CHECK: begin
        if (req_q.opcode) begin
          if (!hd_ok) begin
            res_d.status = ST_EMPTY;
            state_d = FSM_DONE;
          end else begin
            raddr = head_q[AW-1:0];
            state_d = FSM_TAKE;
          end
        end else if (req_q.prefetch && req_q.buffer_busy) begin
          res_d.status = ST_AHEAD_DROP;
          state_d = FSM_DONE;
        end else if (cfg_i.device_size_kb != '0 && cfg_i.device_size_kb < end_sum[32:1]) begin
          res_d.status = ST_PAST_END;
          state_d = FSM_DONE;
        end else if (req_q.buffer_busy || (req_q.is_write && !req_q.buffer_dirty) ||
                     (!req_q.is_write && req_q.buffer_valid)) begin
          res_d.status = ST_SKIPPED;
          state_d = FSM_DONE;
        end else if (cfg_i.merge_enable && hd_ok) begin
          raddr = head_q[AW-1:0];
          addr_d = head_q[AW-1:0];
          first_d = cfg_i.merge_skips_head;
          guard_d = '0;
          state_d = FSM_MERGE;
        end else begin
          state_d = FSM_ALLOC;
        end
      end
      FSM_TAKE: begin
        we = 1'b1;
        waddr = head_q[AW-1:0];
        wdata = {NONE, rd[48:0]};
        used_d[head_q[AW-1:0]] = 1'b0;
        head_d = rd_link;
        res_d.status = ST_HEAD_TAKEN;
        res_d.entry_index = idx6(head_q[AW-1:0]);
        res_d.head_is_write = rd_wr;
        res_d.head_unit = rd_unit;
        res_d.head_sector = rd_sec;
        res_d.head_count = rd_cnt;
        state_d = FSM_DONE;
      end
      FSM_MERGE: begin
        if (first_q) begin
          first_d = 1'b0;
          if (rd_link < NONE) begin
            raddr = rd_link[AW-1:0];
            addr_d = rd_link[AW-1:0];
          end else begin
            state_d = FSM_ALLOC;
          end
        end else if (match_ok && (back_hit || front_hit)) begin
          we = 1'b1;
          waddr = addr_q;
          wdata = {rd_link, cnt_sat, back_hit ? rd_sec : sector_q, rd[8:0]};
          res_d.status = back_hit ? ST_BACK_MERGE : ST_FRONT_MERGE;
          res_d.entry_index = idx6(addr_q);
          state_d = FSM_DONE;
        end else if (rd_link >= NONE || guard_q == LW'(POOL_DEPTH - 1)) begin
          state_d = FSM_ALLOC;
        end else begin
          guard_d = guard_q + LW'(1);
          raddr = rd_link[AW-1:0];
          addr_d = rd_link[AW-1:0];
        end
      end
      FSM_ALLOC: begin
        if (lim != slimit_q) begin
          slimit_d = lim;
          sstart_d = '0;
          idx_d = '0;
        end else begin
          idx_d = sstart_q;
        end
        state_d = FSM_FIND;
      end
      FSM_FIND: begin
        if (!used_q[nidx]) begin
          used_d[nidx] = 1'b1;
          sstart_d = nidx;
          e_d = nidx;
          res_d.status = ST_QUEUED;
          res_d.entry_index = idx6(nidx);
          if (!hd_ok) begin
            we = 1'b1;
            waddr = nidx;
            wdata = {NONE, new_rec};
            head_d = {{(LW-AW){1'b0}}, nidx};
            res_d.start_device = 1'b1;
            state_d = FSM_DONE;
          end else begin
            raddr = head_q[AW-1:0];
            addr_d = head_q[AW-1:0];
            first_d = 1'b1;
            guard_d = '0;
            state_d = FSM_INS;
          end
        end else if (nidx == sstart_q) begin
          res_d.status = req_q.prefetch ? ST_AHEAD_DROP : ST_POOL_FULL;
          state_d = FSM_DONE;
        end else begin
          idx_d = nidx;
        end
      end
      FSM_INS: begin
        if (first_q) begin
          first_d = 1'b0;
          cur_d = rd;
          t_d = addr_q;
          if (rd_link >= NONE) begin
            n_d = rd_link;
            state_d = FSM_WR_E;
          end else begin
            raddr = rd_link[AW-1:0];
            addr_d = rd_link[AW-1:0];
          end
        end else if (brk) begin
          n_d = {{(LW-AW){1'b0}}, addr_q};
          state_d = FSM_WR_E;
        end else begin
          cur_d = rd;
          t_d = addr_q;
          guard_d = guard_q + LW'(1);
          if (rd_link >= NONE || guard_q + LW'(1) == LW'(POOL_DEPTH - 1)) begin
            n_d = rd_link;
            state_d = FSM_WR_E;
          end else begin
            raddr = rd_link[AW-1:0];
            addr_d = rd_link[AW-1:0];
          end
        end
      end
      FSM_WR_E: begin
        we = 1'b1;
        waddr = e_q;
        wdata = {n_q, new_rec};
        state_d = FSM_WR_T;
      end
      FSM_WR_T: begin
        we = 1'b1;
        waddr = t_q;
        wdata = {{(LW-AW){1'b0}}, e_q, cur_q[48:0]};
        state_d = FSM_DONE;
      end
      FSM_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      head_q <= NONE;
      sstart_q <= '0;
      slimit_q <= '0;
      used_q <= '0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      sstart_q <= sstart_d;
      slimit_q <= slimit_d;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; sector_q <= sector_d; addr_q <= addr_d; t_q <= t_d;
    idx_q <= idx_d; e_q <= e_d; first_q <= first_d; guard_q <= guard_d;
    n_q <= n_d; cur_q <= cur_d; res_q <= res_d;
  end

  assign res_o = res_q;
endmodule

// ===== sv/block_request_elevator_queue_unit.sv =====
// Top level: request pool queue with elevator ordering and merging.
`timescale 1ns / 1ps
// channel  | dir | tdata                                    | tuser
// s_axis   | in  | 48b request fields                       | opcode
// m_axis   | out | 56b entry/head fields                    | status
// cfg      | in  | we/idx/wdata write port, no read-back    | -
// One item at a time. A take reads the head entry and frees it; a submit
// runs the merge walk, free search and insert walk, each one memory read
// (registered read data) per step. Reset empties the queue at once via
// per-entry used flops. The result sits in an output register, so a new
// item is taken while it waits on m_axis_tready_i.
module block_request_elevator_queue_unit #(
  parameter int unsigned POOL_DEPTH = 64,
  parameter int unsigned MERGE_LIMIT = 244
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [0] is_write, [1] prefetch, [9:2] unit, [38:10] block_number,
  // [42:39] sectors_per_block, [43] busy, [44] dirty, [45] valid
  input  logic [47:0]                    s_axis_tdata_i,
  input  logic                           s_axis_tuser_i, // [0] opcode
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [5:0] entry_index, [6] start_device, [7] head_is_write,
  // [15:8] head_unit, [47:16] head_sector, [55:48] head_count
  output logic [55:0]                    m_axis_tdata_o,
  output logic [3:0]                     m_axis_tuser_o, // [3:0] status
  input  logic                           cfg_we_i,
  input  logic [breqq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_wdata_i
);
  import breqq_pkg::*;

  cfg_t cfg_q;
  req_t req;
  res_t res, out_q;
  logic res_valid, res_ready, out_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_size_kb   <= '0;
      cfg_q.merge_enable     <= 1'b0;
      cfg_q.merge_skips_head <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEVICE_SIZE_KB:   cfg_q.device_size_kb   <= cfg_wdata_i;
        CFG_MERGE_ENABLE:     cfg_q.merge_enable     <= cfg_wdata_i[0];
        CFG_MERGE_SKIPS_HEAD: cfg_q.merge_skips_head <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign req = '{
    opcode:            s_axis_tuser_i,
    is_write:          s_axis_tdata_i[0],
    prefetch:          s_axis_tdata_i[1],
    unit:              s_axis_tdata_i[9:2],
    block_number:      s_axis_tdata_i[38:10],
    sectors_per_block: s_axis_tdata_i[42:39],
    buffer_busy:       s_axis_tdata_i[43],
    buffer_dirty:      s_axis_tdata_i[44],
    buffer_valid:      s_axis_tdata_i[45]
  };

  breqq_ctrl #(.POOL_DEPTH(POOL_DEPTH), .MERGE_LIMIT(MERGE_LIMIT)) u_ctrl (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .req_valid_i(s_axis_tvalid_i), .req_ready_o(s_axis_tready_o), .req_i(req),
    .res_valid_o(res_valid), .res_ready_i(res_ready), .res_o(res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {out_q.head_count, out_q.head_sector, out_q.head_unit,
                            out_q.head_is_write, out_q.start_device, out_q.entry_index};
endmodule

// ===== tb/sv/tb_block_request_elevator_queue_unit.sv =====
// Testbench for the block request elevator queue: predicts every result item and checks it.
`timescale 1ns / 1ps
module tb_block_request_elevator_queue_unit;
  import breqq_pkg::*;

  localparam int unsigned POOL = 64;
  localparam int unsigned MLIM = 244;
  localparam int unsigned WR_LIM = (POOL * 2) / 3;
  localparam logic [6:0] NIL = 7'(POOL);

  typedef struct packed {
    logic [3:0]  status;
    logic [5:0]  index;
    logic        start;
    logic        h_wr;
    logic [7:0]  h_unit;
    logic [31:0] h_sector;
    logic [7:0]  h_count;
  } disk_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic [3:0] m_axis_tuser_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_DEVICE_SIZE_KB;
  logic [31:0] cfg_wdata_i = '0;

  block_request_elevator_queue_unit u_dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // Shadow of the queue state used for prediction.
  logic [31:0] dev_kb;
  logic        mrg_en, mrg_skip_head;
  logic        e_used [POOL];
  logic        e_wr [POOL];
  logic [7:0]  e_unit [POOL];
  logic [31:0] e_sector [POOL];
  logic [8:0]  e_count [POOL];
  logic [6:0]  e_link [POOL];
  logic [6:0]  q_head;
  logic [6:0]  free_pos;
  logic [6:0]  free_lim;

  req_t       pending_reqs [$];
  disk_res_t  expected_res [$];
  int         n_queued;      // entries currently held in shadow pool
  bit         failed = 1'b0;
  bit         calm = 1'b0;   // no idling near the end
  bit         hold_send = 1'b0;
  int         rx_hold = 0;   // long receiver stall, in cycles

  function automatic bit goes_first(int a, int b);
    if (e_wr[a] != e_wr[b]) return e_wr[a] < e_wr[b];
    if (e_unit[a] != e_unit[b]) return e_unit[a] < e_unit[b];
    return e_sector[a] < e_sector[b];
  endfunction

  function automatic logic [6:0] grab_free(logic [6:0] lim);
    logic [6:0] idx;
    if (lim != free_lim) begin
      free_lim = lim;
      free_pos = 0;
    end
    idx = free_pos;
    forever begin
      idx = ((idx > 0) ? idx : lim) - 7'd1;
      if (idx < POOL && !e_used[idx]) break;
      if (idx == free_pos) return NIL;
    end
    free_pos = idx;
    return idx;
  endfunction

  function automatic void elevator_insert(int e);
    int t, n, guard;
    t = q_head;
    guard = 0;
    while (t < POOL && e_link[t] < POOL && guard < POOL) begin
      n = e_link[t];
      if ((goes_first(t, e) || !goes_first(t, n)) && goes_first(e, n)) break;
      t = n;
      guard++;
    end
    if (t < POOL) begin
      e_link[e] = e_link[t];
      e_link[t] = 7'(e);
    end
  endfunction

  function automatic disk_res_t predict_disk(req_t q);
    disk_res_t r;
    logic [31:0] sector;
    logic [3:0] cnt;
    logic [6:0] e;
    int rr, guard;
    bit done;
    r = '0;
    if (q.opcode) begin
      if (q_head >= POOL) begin
        r.status = ST_EMPTY;
        return r;
      end
      e = q_head;
      q_head = e_link[e];
      e_link[e] = NIL;
      e_used[e] = 1'b0;
      n_queued--;
      r.status = ST_HEAD_TAKEN;
      r.index = e[5:0];
      r.h_wr = e_wr[e];
      r.h_unit = e_unit[e];
      r.h_sector = e_sector[e];
      r.h_count = e_count[e][7:0];
      return r;
    end
    cnt = q.sectors_per_block;
    sector = 32'(q.block_number) * 32'(cnt);
    if (q.prefetch && q.buffer_busy) r.status = ST_AHEAD_DROP;
    else if (dev_kb != 0 && {1'b0, dev_kb} < ((33'(sector) + 33'(cnt)) >> 1))
      r.status = ST_PAST_END;
    else if (q.buffer_busy || (q.is_write && !q.buffer_dirty) ||
             (!q.is_write && q.buffer_valid))
      r.status = ST_SKIPPED;
    else begin
      done = 1'b0;
      r.status = ST_POOL_FULL;
      if (mrg_en && q_head < POOL) begin
        rr = q_head;
        guard = 0;
        if (mrg_skip_head) rr = e_link[rr];
        while (rr < POOL && guard < POOL && !done) begin
          if (e_unit[rr] == q.unit && e_wr[rr] == q.is_write && e_count[rr] < MLIM) begin
            if (e_sector[rr] + 32'(e_count[rr]) == sector) begin
              e_count[rr] = (e_count[rr] + cnt > 255) ? 9'd255 : e_count[rr] + cnt;
              r.status = ST_BACK_MERGE; r.index = rr[5:0]; done = 1'b1;
            end else if (e_sector[rr] - 32'(cnt) == sector) begin
              e_count[rr] = (e_count[rr] + cnt > 255) ? 9'd255 : e_count[rr] + cnt;
              e_sector[rr] = sector;
              r.status = ST_FRONT_MERGE; r.index = rr[5:0]; done = 1'b1;
            end
          end
          rr = e_link[rr];
          guard++;
        end
      end
      if (!done) begin
        e = grab_free(q.is_write ? 7'(WR_LIM) : 7'(POOL));
        if (e >= POOL) r.status = q.prefetch ? ST_AHEAD_DROP : ST_POOL_FULL;
        else begin
          e_used[e] = 1'b1;
          e_wr[e] = q.is_write;
          e_unit[e] = q.unit;
          e_sector[e] = sector;
          e_count[e] = 9'(cnt);
          e_link[e] = NIL;
          n_queued++;
          if (q_head >= POOL) begin
            q_head = e;
            r.start = 1'b1;
          end else elevator_insert(e);
          r.status = ST_QUEUED;
          r.index = e[5:0];
        end
      end
    end
    return r;
  endfunction

  // Driver: one item at a time from the pending queue, random bursts of idling.
  int tx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_res.push_back(predict_disk(pending_reqs.pop_front()));
        if (!calm && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 4);
      end
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (!(s_axis_tvalid_i && !s_axis_tready_o) &&
                   (pending_reqs.size() == 0 || hold_send)) begin
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_send) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i <= pending_reqs[0].opcode;
        s_axis_tdata_i <= {2'b0, pending_reqs[0].buffer_valid, pending_reqs[0].buffer_dirty,
                           pending_reqs[0].buffer_busy, pending_reqs[0].sectors_per_block,
                           pending_reqs[0].block_number, pending_reqs[0].unit,
                           pending_reqs[0].prefetch, pending_reqs[0].is_write};
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  int rx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        m_axis_tready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        rx_gap <= $urandom_range(0, 3);
        m_axis_tready_i <= 1'b0;
      end else m_axis_tready_i <= 1'b1;
    end
  end

  // Monitor: compare each result item with the oldest expectation.
  always @(posedge clk_i) begin
    disk_res_t got, exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tuser_o, m_axis_tdata_o[5:0], m_axis_tdata_o[6], m_axis_tdata_o[7],
             m_axis_tdata_o[15:8], m_axis_tdata_o[47:16], m_axis_tdata_o[55:48]};
      if (expected_res.size() == 0) begin
        failed = 1'b1;
        $display("%0t: unexpected result item %h", $time, got);
      end else begin
        exp_r = expected_res.pop_front();
        if (got !== exp_r) begin
          failed = 1'b1;
          $display("%0t: status exp %0d got %0d, index exp %0d got %0d, start exp %0d got %0d",
                   $time, exp_r.status, got.status, exp_r.index, got.index,
                   exp_r.start, got.start);
          $display("%0t: head wr/unit/sector/count exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                   $time, exp_r.h_wr, exp_r.h_unit, exp_r.h_sector, exp_r.h_count,
                   got.h_wr, got.h_unit, got.h_sector, got.h_count);
        end
      end
    end
  end

  function automatic req_t make_sub(bit wr, bit ahead, logic [7:0] u, logic [28:0] blk,
                                    logic [3:0] spb);
    req_t q;
    q = '0;
    q.is_write = wr;
    q.prefetch = ahead;
    q.unit = u;
    q.block_number = blk;
    q.sectors_per_block = spb;
    q.buffer_dirty = wr;   // something to do
    q.buffer_valid = 1'b0;
    return q;
  endfunction

  function automatic req_t make_take();
    req_t q;
    q = '0;
    q.opcode = 1'b1;
    return q;
  endfunction

  // Mostly well-formed submits on few units and nearby blocks so merges happen.
  function automatic req_t random_item(int take_pct);
    req_t q;
    if ($urandom_range(0, 99) < take_pct) return make_take();
    q = make_sub(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
                 8'($urandom_range(0, 3)), 29'($urandom_range(0, 40)),
                 4'($urandom_range(1, 8)));
    if ($urandom_range(0, 9) == 0) begin
      q = 47'({$urandom, $urandom});
      q.opcode = 1'b0;
      q.block_number = 29'($urandom); // noise across every bit
      q.unit = 8'($urandom);
    end else if ($urandom_range(0, 4) == 0) begin
      q.buffer_busy = 1'($urandom);
      q.buffer_dirty = 1'($urandom);
      q.buffer_valid = 1'($urandom);
    end
    return q;
  endfunction

  task automatic wait_drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid_i || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (3 * POOL + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DEVICE_SIZE_KB) dev_kb = val;
    else if (idx == CFG_MERGE_ENABLE) mrg_en = val[0];
    else mrg_skip_head = val[0];
  endtask

  task automatic empty_queue();
    repeat (n_queued + 1) pending_reqs.push_back(make_take());
    wait_drain();
  endtask

  initial begin
    dev_kb = '0;
    mrg_en = 1'b0;
    mrg_skip_head = 1'b1;
    for (int i = 0; i < POOL; i++) begin
      e_used[i] = 1'b0; e_wr[i] = 1'b0; e_unit[i] = '0;
      e_sector[i] = '0; e_count[i] = '0; e_link[i] = NIL;
    end
    q_head = NIL;
    free_pos = '0;
    free_lim = '0;
    n_queued = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty take, reset settings, special cases.
    pending_reqs.push_back(make_take());
    pending_reqs.push_back(make_sub(1'b0, 1'b0, 8'd0, 29'd0, 4'd1));
    pending_reqs.push_back(make_sub(1'b1, 1'b0, 8'hff, 29'h1fffffff, 4'd15));  // sector wrap
    pending_reqs.push_back(make_sub(1'b0, 1'b0, 8'd3, 29'd7, 4'd0));           // zero size
    pending_reqs.push_back(make_sub(1'b0, 1'b0, 8'd3, 29'd9, 4'd9));           // odd size
    begin
      req_t q;
      q = make_sub(1'b1, 1'b1, 8'd1, 29'd2, 4'd2); q.buffer_busy = 1'b1;
      pending_reqs.push_back(q);
      q = make_sub(1'b1, 1'b0, 8'd1, 29'd2, 4'd2); q.buffer_busy = 1'b1;
      pending_reqs.push_back(q);
      q = make_sub(1'b1, 1'b0, 8'd1, 29'd2, 4'd2); q.buffer_dirty = 1'b0;
      pending_reqs.push_back(q);
      q = make_sub(1'b0, 1'b0, 8'd1, 29'd2, 4'd2); q.buffer_valid = 1'b1;
      pending_reqs.push_back(q);
    end
    wait_drain();
    empty_queue();

    // Past-end cases, then merging with the head included, up to the merge count limit.
    write_reg(CFG_MERGE_ENABLE, 32'd1);
    write_reg(CFG_DEVICE_SIZE_KB, 32'd1);   // tiny device: past-end cases
    pending_reqs.push_back(make_sub(1'b0, 1'b0, 8'd0, 29'd0, 4'd2));
    pending_reqs.push_back(make_sub(1'b0, 1'b0, 8'd0, 29'd1, 4'd2));
    wait_drain();
    write_reg(CFG_DEVICE_SIZE_KB, 32'hffffffff);
    write_reg(CFG_MERGE_SKIPS_HEAD, 32'd0);
    for (int i = 0; i < 40; i++)
      pending_reqs.push_back(make_sub(1'b0, 1'b0, 8'd5, 29'(i), 4'd8));
    pending_reqs.push_back(make_sub(1'b0, 1'b0, 8'd5, 29'd1000, 4'd8));
    pending_reqs.push_back(make_sub(1'b0, 1'b0, 8'd5, 29'd999, 4'd8));     // front merge
    wait_drain();
    empty_queue();

    // Fill the pool: writes stop at two thirds, reads at full, ahead drops.
    write_reg(CFG_MERGE_ENABLE, 32'd0);
    write_reg(CFG_DEVICE_SIZE_KB, 32'd0);
    for (int i = 0; i < 50; i++)
      pending_reqs.push_back(make_sub(1'b1, i[0], 8'($urandom), 29'($urandom), 4'd1));
    for (int i = 0; i < 40; i++)
      pending_reqs.push_back(make_sub(1'b0, i[0], 8'($urandom), 29'($urandom), 4'd2));
    rx_hold = 400;   // receiver holds off while the sender keeps offering
    wait_drain();
    empty_queue();

    // Random phases over several settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_MERGE_ENABLE, 32'(ph != 1));
      write_reg(CFG_MERGE_SKIPS_HEAD, 32'(ph[0]));
      write_reg(CFG_DEVICE_SIZE_KB, (ph == 2) ? 32'd12 : (ph == 3) ? $urandom : 32'd0);
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 120; i++) pending_reqs.push_back(random_item(ph == 4 ? 10 : 30));
      if (ph == 2) begin
        while (pending_reqs.size() > 60) @(posedge clk_i);
        hold_send = 1'b1;   // pause until every result is in
        while (expected_res.size() > 0 || s_axis_tvalid_i) @(posedge clk_i);
        hold_send = 1'b0;
      end
      wait_drain();
      if (ph != 4) empty_queue();
    end

    if (!failed) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
sv/breqq_pkg.sv
sv/breqq_ram.sv
sv/breqq_ctrl.sv
sv/block_request_elevator_queue_unit.sv
tb/sv/tb_block_request_elevator_queue_unit.sv
